// File: design/erc_pkg.sv
// shared types, wiring tables and mod-26 helpers for the rotor cipher
`default_nettype none

package erc_pkg;

    localparam int LETTERS = 26;
    localparam logic [5:0] LETTERS_W = 6'(LETTERS);
    localparam logic [7:0] CHAR_A = 8'd65;
    localparam logic [7:0] CHAR_Z = 8'd90;
    localparam int CFG_W = 60;
    localparam int PLUG_GROUP = 12;
    localparam int PLUG_HIGH_N = 2;

    typedef logic [4:0] t_letter;
    typedef logic [2:0] t_rsel;

    typedef enum logic [2:0] {
        REG_ROTOR_LEFT   = 3'd0,
        REG_ROTOR_MIDDLE = 3'd1,
        REG_ROTOR_RIGHT  = 3'd2,
        REG_START_POS    = 3'd3,
        REG_PLUG_LOW     = 3'd4,
        REG_PLUG_MID     = 3'd5,
        REG_PLUG_HIGH    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic             en;
        t_reg_idx         idx;
        logic [CFG_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        t_rsel left;
        t_rsel middle;
        t_rsel right;
    } t_rotor_sel;

    // one queued item: classified code plus rotor positions after its step
    typedef struct packed {
        logic       letter;
        logic [7:0] code;
        t_letter    idx;
        t_letter    lpos;
        t_letter    mpos;
        t_letter    rpos;
    } t_job;

    typedef struct packed {
        t_job    job;
        t_letter sig;
    } t_work;

    typedef logic [8*LETTERS-1:0] t_wiring;

    localparam t_wiring FWD_TAB [5] = '{
        "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
        "AJDKSIRUXBLHWTMCQGZNPYFVOE",
        "BDFHJLCPRTXVZNYEIWGAKMUSQO",
        "ESOVPZJAYQUIRHXLNFTGKDCMWB",
        "VZBRGITYUPSDNHLXAWMJQOFECK"
    };

    // inverse wirings for the return path
    localparam t_wiring INV_TAB [5] = '{
        "UWYGADFPVZBECKMTHXSLRINQOJ",
        "AJPCZWRLFBDKOTYUQGENHXMIVS",
        "TAGBPCSDQEUFVNZHYIXJWLRKOM",
        "HZWVARTNLGUPXQCEJMBSKDYOIF",
        "QCYLXWENFTZOSMVJUDKGIARPHB"
    };

    localparam t_wiring REFL_TAB = "YRUHQSLDPXNGOKMIEBFZCWVJAT";

    localparam t_letter NOTCH_TAB [5] = '{5'd16, 5'd4, 5'd21, 5'd9, 5'd25};

    function automatic t_rsel sel_rotor(logic [2:0] rtype);
        t_rsel s;
        if (rtype == 3'd0) s = 3'd0;
        else if (rtype > 3'd5) s = 3'd4;
        else s = rtype - 3'd1;
        return s;
    endfunction

    function automatic t_letter add_mod(t_letter a, t_letter b);
        logic [5:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= LETTERS_W) sum = sum - LETTERS_W;
        return sum[4:0];
    endfunction

    function automatic t_letter sub_mod(t_letter a, t_letter b);
        logic [5:0] d;
        d = {1'b0, a} + LETTERS_W - {1'b0, b};
        if (d >= LETTERS_W) d = d - LETTERS_W;
        return d[4:0];
    endfunction

    function automatic t_letter red_mod(t_letter v);
        logic [5:0] w;
        w = {1'b0, v};
        if (w >= LETTERS_W) w = w - LETTERS_W;
        return w[4:0];
    endfunction

    function automatic t_letter char_lookup(t_wiring tab, t_letter idx);
        logic [7:0] ch;
        ch = CHAR_A;
        if ({1'b0, idx} < LETTERS_W) ch = tab[8*(LETTERS-1-int'(idx)) +: 8];
        return t_letter'(ch - CHAR_A);
    endfunction

    // plug entry k in 1..26 maps the letter to letter k-1, anything else is unplugged
    function automatic t_letter plug_dec(t_letter e, t_letter letter);
        t_letter r;
        if (e >= 5'd1 && {1'b0, e} <= LETTERS_W) r = e - 5'd1;
        else r = letter;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/erc_front.sv
// front end: takes characters, steps the rotors and queues classified items
`default_nettype none

module erc_front
    import erc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_char_code,
    input  wire t_cfg_wr    i_cfg,
    input  wire t_rotor_sel i_rsel,
    input  wire logic       i_q_ready,
    output logic            o_push,
    output t_job            o_job
);

    t_letter r_lpos, r_mpos, r_rpos;
    t_letter n_lpos, n_mpos, n_rpos;
    logic    is_letter, mid_notch, right_notch, accept;

    assign accept    = i_valid && i_q_ready;
    assign is_letter = (i_char_code >= CHAR_A) && (i_char_code <= CHAR_Z);
    assign mid_notch   = (r_mpos == NOTCH_TAB[i_rsel.middle]);
    assign right_notch = (r_rpos == NOTCH_TAB[i_rsel.right]);

    always_comb begin
        n_lpos = r_lpos;
        n_mpos = r_mpos;
        n_rpos = r_rpos;
        if (is_letter) begin
            // double step: a middle rotor at its notch carries the left one with it
            if (mid_notch) begin
                n_lpos = add_mod(r_lpos, 5'd1);
                n_mpos = add_mod(r_mpos, 5'd1);
            end else if (right_notch) begin
                n_mpos = add_mod(r_mpos, 5'd1);
            end
            n_rpos = add_mod(r_rpos, 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpos <= '0;
            r_mpos <= '0;
            r_rpos <= '0;
        end else if (i_cfg.en && i_cfg.idx == REG_START_POS) begin
            r_lpos <= red_mod(i_cfg.data[4:0]);
            r_mpos <= red_mod(i_cfg.data[9:5]);
            r_rpos <= red_mod(i_cfg.data[14:10]);
        end else if (accept) begin
            r_lpos <= n_lpos;
            r_mpos <= n_mpos;
            r_rpos <= n_rpos;
        end
    end

    assign o_ready      = i_q_ready;
    assign o_push       = accept;
    assign o_job.letter = is_letter;
    assign o_job.code   = i_char_code;
    assign o_job.idx    = is_letter ? t_letter'(i_char_code - CHAR_A) : '0;
    assign o_job.lpos   = n_lpos;
    assign o_job.mpos   = n_mpos;
    assign o_job.rpos   = n_rpos;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_lpos} < LETTERS_W) && ({1'b0, r_mpos} < LETTERS_W)
            && ({1'b0, r_rpos} < LETTERS_W))
        else $error("rotor position out of range");

endmodule

`default_nettype wire

// File: design/erc_queue.sv
// short item queue between the front end and the cipher pipeline
`default_nettype none

module erc_queue
    import erc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_job      o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_ready = (r_cnt != FULL);
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL)
        else $error("queue fill count above depth");

endmodule

`default_nettype wire

// File: design/erc_back.sv
// back end: plugboard, rotor and reflector passes, one per pipeline stage
`default_nettype none

module erc_back
    import erc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg_wr    i_cfg,
    input  wire t_rotor_sel i_rsel,
    input  wire logic       i_q_valid,
    input  wire t_job       i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_code,
    output logic [4:0]      o_left_position,
    output logic [4:0]      o_middle_position,
    output logic [4:0]      o_right_position
);

    localparam int ST_PLUG_IN  = 0;
    localparam int ST_FWD_R    = 1;
    localparam int ST_FWD_M    = 2;
    localparam int ST_FWD_L    = 3;
    localparam int ST_REFLECT  = 4;
    localparam int ST_BACK_L   = 5;
    localparam int ST_BACK_M   = 6;
    localparam int ST_BACK_R   = 7;
    localparam int ST_PLUG_OUT = 8;
    localparam int NSTG        = 9;

    t_letter          r_plug_in  [LETTERS];
    t_letter          r_plug_out [LETTERS];
    t_work            r_stg [NSTG];
    t_work            n_stg [NSTG];
    logic [NSTG-1:0]  r_vld;
    logic             adv;

    // the whole pipeline moves when the output register is free or taken
    assign adv   = !r_vld[NSTG-1] || i_ready;
    assign o_pop = adv && i_q_valid;

    // plugboard copies, one for the entry pass and one for the exit pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LETTERS; i++) begin
                r_plug_in[i]  <= t_letter'(i);
                r_plug_out[i] <= t_letter'(i);
            end
        end else if (i_cfg.en) begin
            case (i_cfg.idx)
                REG_PLUG_LOW: begin
                    for (int i = 0; i < PLUG_GROUP; i++) begin
                        r_plug_in[i]  <= plug_dec(i_cfg.data[5*i +: 5], t_letter'(i));
                        r_plug_out[i] <= plug_dec(i_cfg.data[5*i +: 5], t_letter'(i));
                    end
                end
                REG_PLUG_MID: begin
                    for (int i = 0; i < PLUG_GROUP; i++) begin
                        r_plug_in[PLUG_GROUP+i] <=
                            plug_dec(i_cfg.data[5*i +: 5], t_letter'(PLUG_GROUP + i));
                        r_plug_out[PLUG_GROUP+i] <=
                            plug_dec(i_cfg.data[5*i +: 5], t_letter'(PLUG_GROUP + i));
                    end
                end
                REG_PLUG_HIGH: begin
                    for (int i = 0; i < PLUG_HIGH_N; i++) begin
                        r_plug_in[2*PLUG_GROUP+i] <=
                            plug_dec(i_cfg.data[5*i +: 5], t_letter'(2*PLUG_GROUP + i));
                        r_plug_out[2*PLUG_GROUP+i] <=
                            plug_dec(i_cfg.data[5*i +: 5], t_letter'(2*PLUG_GROUP + i));
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        t_work w;
        t_letter pin;
        w.job = i_job;
        w.sig = r_plug_in[i_job.idx];
        n_stg[ST_PLUG_IN] = w;
        for (int k = 1; k < NSTG; k++) begin
            w = r_stg[k-1];
            pin = '0;
            case (k)
                ST_FWD_R: begin
                    pin   = add_mod(w.sig, w.job.rpos);
                    w.sig = sub_mod(char_lookup(FWD_TAB[i_rsel.right], pin), w.job.rpos);
                end
                ST_FWD_M: begin
                    pin   = add_mod(w.sig, w.job.mpos);
                    w.sig = sub_mod(char_lookup(FWD_TAB[i_rsel.middle], pin), w.job.mpos);
                end
                ST_FWD_L: begin
                    pin   = add_mod(w.sig, w.job.lpos);
                    w.sig = sub_mod(char_lookup(FWD_TAB[i_rsel.left], pin), w.job.lpos);
                end
                ST_REFLECT: begin
                    w.sig = char_lookup(REFL_TAB, w.sig);
                end
                ST_BACK_L: begin
                    pin   = add_mod(w.sig, w.job.lpos);
                    w.sig = sub_mod(char_lookup(INV_TAB[i_rsel.left], pin), w.job.lpos);
                end
                ST_BACK_M: begin
                    pin   = add_mod(w.sig, w.job.mpos);
                    w.sig = sub_mod(char_lookup(INV_TAB[i_rsel.middle], pin), w.job.mpos);
                end
                ST_BACK_R: begin
                    pin   = add_mod(w.sig, w.job.rpos);
                    w.sig = sub_mod(char_lookup(INV_TAB[i_rsel.right], pin), w.job.rpos);
                end
                ST_PLUG_OUT: begin
                    // non-letters keep their code untouched
                    if (w.job.letter) begin
                        w.job.code = CHAR_A + {3'b000, r_plug_out[w.sig]};
                    end
                end
                default: ;
            endcase
            n_stg[k] = w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < NSTG; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_q_valid};
        end
    end

    assign o_valid           = r_vld[NSTG-1];
    assign o_out_code        = r_stg[NSTG-1].job.code;
    assign o_left_position   = r_stg[NSTG-1].job.lpos;
    assign o_middle_position = r_stg[NSTG-1].job.mpos;
    assign o_right_position  = r_stg[NSTG-1].job.rpos;

    a_letter_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && r_stg[NSTG-1].job.letter)
            |-> (r_stg[NSTG-1].job.code >= CHAR_A && r_stg[NSTG-1].job.code <= CHAR_Z))
        else $error("enciphered item is not a capital letter");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && !i_ready) |=> (r_vld[NSTG-1] && $stable(r_vld)))
        else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire

// File: design/enigma_rotor_cipher.sv
// top level of the three-rotor cipher: config registers, front end, queue, pipeline
//
//  port group   dir  handshake          payload
//  input item   in   i_valid / o_ready  i_char_code
//  result item  out  o_valid / i_ready  o_out_code, o_left/middle/right_position
//  config       in   i_cfg_we           i_cfg_idx, i_cfg_data
//
// one item per cycle sustained while i_ready is held high; an accepted item is first
// written into the queue, then passes through the nine pipeline stages to o_valid
// rotor stepping is done at acceptance, so the next item can follow at once
// synchronous active-low reset zeroes positions, sets rotor types I, II, III
// and makes the plugboard straight through
// a stalled output freezes the pipeline; the queue keeps taking items until full
`default_nettype none

module enigma_rotor_cipher
    import erc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_char_code,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_code,
    output logic [4:0]       o_left_position,
    output logic [4:0]       o_middle_position,
    output logic [4:0]       o_right_position,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [59:0] i_cfg_data
);

    logic [2:0] r_rotor_left, r_rotor_middle, r_rotor_right;
    t_cfg_wr    cfg;
    t_rotor_sel rsel;
    logic       push, q_ready, q_valid, pop;
    t_job       push_job, head_job;

    assign cfg.en   = i_cfg_we;
    assign cfg.idx  = t_reg_idx'(i_cfg_idx);
    assign cfg.data = i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotor_left   <= 3'd1;
            r_rotor_middle <= 3'd2;
            r_rotor_right  <= 3'd3;
        end else if (cfg.en) begin
            unique case (cfg.idx)
                REG_ROTOR_LEFT:   r_rotor_left   <= cfg.data[2:0];
                REG_ROTOR_MIDDLE: r_rotor_middle <= cfg.data[2:0];
                REG_ROTOR_RIGHT:  r_rotor_right  <= cfg.data[2:0];
                default: ;
            endcase
        end
    end

    assign rsel.left   = sel_rotor(r_rotor_left);
    assign rsel.middle = sel_rotor(r_rotor_middle);
    assign rsel.right  = sel_rotor(r_rotor_right);

    erc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .i_cfg       (cfg),
        .i_rsel      (rsel),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_job       (push_job)
    );

    erc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (head_job)
    );

    erc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_rsel            (rsel),
        .i_q_valid         (q_valid),
        .i_job             (head_job),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_out_code        (o_out_code),
        .o_left_position   (o_left_position),
        .o_middle_position (o_middle_position),
        .o_right_position  (o_right_position)
    );

endmodule

`default_nettype wire

// File: tb/enigma_rotor_cipher_test.sv
// self-checking testbench for the three-rotor cipher with its own stepping and wiring predictor
`default_nettype none

import erc_pkg::*;

typedef struct packed {
    logic [7:0] code;
    logic [4:0] lpos;
    logic [4:0] mpos;
    logic [4:0] rpos;
} cipher_result_t;

class cipher_scoreboard;
    int rotor_left;
    int rotor_middle;
    int rotor_right;
    int left_pos;
    int middle_pos;
    int right_pos;
    int plug[26];
    cipher_result_t expected_ciphertext[$];
    int errors;

    function new();
        rotor_left = 1;
        rotor_middle = 2;
        rotor_right = 3;
        left_pos = 0;
        middle_pos = 0;
        right_pos = 0;
        errors = 0;
        for (int i = 0; i < 26; i++) plug[i] = i;
    endfunction

    // out-of-range types fold onto rotor I or rotor V
    function int rotor_slot(int rtype);
        if (rtype == 0) return 0;
        if (rtype > 5) return 4;
        return rtype - 1;
    endfunction

    function int notch_of(int rtype);
        case (rotor_slot(rtype))
            0: return 16;
            1: return 4;
            2: return 21;
            3: return 9;
            default: return 25;
        endcase
    endfunction

    function int wiring(int slot, int pin);
        string w;
        case (slot)
            0: w = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
            1: w = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
            2: w = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
            3: w = "ESOVPZJAYQUIRHXLNFTGKDCMWB";
            default: w = "VZBRGITYUPSDNHLXAWMJQOFECK";
        endcase
        return int'(w[pin]) - 65;
    endfunction

    function int pass_forward(int s, int rtype, int pos);
        int pin;
        pin = (s + pos) % 26;
        return (wiring(rotor_slot(rtype), pin) + 26 - pos) % 26;
    endfunction

    function int pass_reverse(int s, int rtype, int pos);
        int pin;
        int found;
        pin = (s + pos) % 26;
        found = 0;
        for (int i = 25; i >= 0; i--)
            if (wiring(rotor_slot(rtype), i) == pin) found = i;
        return (found + 26 - pos) % 26;
    endfunction

    function void fill_plugs(int first, int count, logic [59:0] value);
        int e;
        for (int i = 0; i < count; i++) begin
            e = int'(value[5*i +: 5]);
            plug[first + i] = (e >= 1 && e <= 26) ? e - 1 : first + i;
        end
    endfunction

    function void write_reg(logic [2:0] idx, logic [59:0] data);
        case (idx)
            REG_ROTOR_LEFT: rotor_left = int'(data[2:0]);
            REG_ROTOR_MIDDLE: rotor_middle = int'(data[2:0]);
            REG_ROTOR_RIGHT: rotor_right = int'(data[2:0]);
            REG_START_POS: begin
                left_pos = int'(data[4:0]) % 26;
                middle_pos = int'(data[9:5]) % 26;
                right_pos = int'(data[14:10]) % 26;
            end
            REG_PLUG_LOW: fill_plugs(0, 12, data);
            REG_PLUG_MID: fill_plugs(12, 12, data);
            REG_PLUG_HIGH: fill_plugs(24, 2, data);
            default: ;
        endcase
    endfunction

    // for a letter, step the rotors, then run it through the whole signal path; other codes pass unchanged
    function void note_char(logic [7:0] c);
        cipher_result_t r;
        bit right_at_notch;
        bit middle_at_notch;
        int s;
        r.code = c;
        if (c >= 8'd65 && c <= 8'd90) begin
            right_at_notch = right_pos == notch_of(rotor_right);
            middle_at_notch = middle_pos == notch_of(rotor_middle);
            if (middle_at_notch) begin
                left_pos = (left_pos + 1) % 26;
                middle_pos = (middle_pos + 1) % 26;
            end else if (right_at_notch) begin
                middle_pos = (middle_pos + 1) % 26;
            end
            right_pos = (right_pos + 1) % 26;
            s = plug[int'(c) - 65];
            s = pass_forward(s, rotor_right, right_pos);
            s = pass_forward(s, rotor_middle, middle_pos);
            s = pass_forward(s, rotor_left, left_pos);
            s = wiring_reflect(s);
            s = pass_reverse(s, rotor_left, left_pos);
            s = pass_reverse(s, rotor_middle, middle_pos);
            s = pass_reverse(s, rotor_right, right_pos);
            s = plug[s];
            r.code = 8'(s + 65);
        end
        r.lpos = 5'(left_pos);
        r.mpos = 5'(middle_pos);
        r.rpos = 5'(right_pos);
        expected_ciphertext.push_back(r);
    endfunction

    function int wiring_reflect(int s);
        string w;
        w = "YRUHQSLDPXNGOKMIEBFZCWVJAT";
        return int'(w[s]) - 65;
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    function void check_result(logic [7:0] code, logic [4:0] lpos, logic [4:0] mpos,
                               logic [4:0] rpos);
        cipher_result_t want;
        if (expected_ciphertext.size() == 0) begin
            $error("out_code: no item pending, got %0d", code);
            errors++;
            return;
        end
        want = expected_ciphertext.pop_front();
        compare_field("out_code", want.code, code);
        compare_field("left_position", 8'(want.lpos), 8'(lpos));
        compare_field("middle_position", 8'(want.mpos), 8'(mpos));
        compare_field("right_position", 8'(want.rpos), 8'(rpos));
    endfunction
endclass

module enigma_rotor_cipher_test;

    localparam int PIPE_LATENCY = 10;
    localparam int LIMIT_CYCLES = 300000;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_char_code = 8'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_out_code;
    logic [4:0]  o_left_position;
    logic [4:0]  o_middle_position;
    logic [4:0]  o_right_position;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = 3'd0;
    logic [59:0] i_cfg_data = 60'd0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;

    cipher_scoreboard sb = new();

    enigma_rotor_cipher u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_char_code       (i_char_code),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_out_code        (o_out_code),
        .o_left_position   (o_left_position),
        .o_middle_position (o_middle_position),
        .o_right_position  (o_right_position),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_char(i_char_code);
            if (o_valid && i_ready)
                sb.check_result(o_out_code, o_left_position, o_middle_position,
                                o_right_position);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("enigma_rotor_cipher_test: done, errors");
            $finish;
        end
    end

    // all tasks start and end at a falling edge
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_code <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_block();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.expected_ciphertext.size() != 0) @(negedge i_clk);
        repeat (PIPE_LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [59:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_idling(input idle_mode_e mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0; recv_stall_pct = 0; end
            IDLE_SENDER: begin send_idle_pct = 74; recv_stall_pct = 0; end
            IDLE_RECEIVER: begin send_idle_pct = 0; recv_stall_pct = 74; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
        endcase
    endtask

    // either a consistent set of swapped pairs or raw random entries
    task automatic program_plugboard(input int pairs, input bit scramble);
        int order[26];
        logic [4:0] entry[26];
        logic [129:0] packed_map;
        int j;
        int t;
        if (scramble) begin
            packed_map = {2'($urandom), 64'({$urandom, $urandom}), 64'({$urandom, $urandom})};
        end else begin
            for (int i = 0; i < 26; i++) begin
                order[i] = i;
                case ($urandom_range(3))
                    1: entry[i] = 5'(i + 1);
                    2: entry[i] = 5'($urandom_range(31, 27));
                    default: entry[i] = 5'd0;
                endcase
            end
            for (int i = 25; i > 0; i--) begin
                j = $urandom_range(i);
                t = order[i];
                order[i] = order[j];
                order[j] = t;
            end
            for (int p = 0; p < pairs; p++) begin
                entry[order[2*p]] = 5'(order[2*p+1] + 1);
                entry[order[2*p+1]] = 5'(order[2*p] + 1);
            end
            for (int i = 0; i < 26; i++) packed_map[5*i +: 5] = entry[i];
        end
        write_reg(REG_PLUG_LOW, packed_map[59:0]);
        write_reg(REG_PLUG_MID, packed_map[119:60]);
        write_reg(REG_PLUG_HIGH, 60'(packed_map[129:120]));
    endtask

    task automatic configure_random();
        int lp;
        int mp;
        int rp;
        write_reg(REG_ROTOR_LEFT, 60'($urandom_range(99) < 80 ? $urandom_range(5, 1)
                                                              : $urandom_range(7)));
        write_reg(REG_ROTOR_MIDDLE, 60'($urandom_range(99) < 80 ? $urandom_range(5, 1)
                                                                : $urandom_range(7)));
        write_reg(REG_ROTOR_RIGHT, 60'($urandom_range(99) < 80 ? $urandom_range(5, 1)
                                                               : $urandom_range(7)));
        if ($urandom_range(1) == 1) begin
            // park middle and right at or just short of their notches to hit the double step
            lp = $urandom_range(31);
            mp = (sb.notch_of(sb.rotor_middle) + 26 - $urandom_range(1)) % 26;
            rp = (sb.notch_of(sb.rotor_right) + 26 - $urandom_range(3)) % 26;
            write_reg(REG_START_POS, 60'(lp | (mp << 5) | (rp << 10)));
        end else begin
            write_reg(REG_START_POS, 60'($urandom_range(32767)));
        end
        program_plugboard($urandom_range(13), $urandom_range(9) == 0);
        if ($urandom_range(3) == 0) write_reg(REG_UNUSED, 60'({$urandom, $urandom}));
    endtask

    function automatic logic [7:0] random_char();
        if ($urandom_range(99) < 75) return 8'(65 + $urandom_range(25));
        return 8'($urandom_range(255));
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: letters at both ends and non-letter codes, some just outside the letter range
        set_idling(IDLE_NONE);
        send_char(8'd65);
        send_char(8'd90);
        send_char(8'd0);
        send_char(8'd255);
        send_char(8'd64);
        send_char(8'd91);
        send_char(8'd97);

        // middle one short of its notch, right one short of its notch: double step
        drain_block();
        write_reg(REG_START_POS, 60'((3 << 5) | (20 << 10)));
        send_char(8'd65);
        send_char(8'd66);
        send_char(8'd67);
        send_char(8'd68);

        // out-of-range rotor types, position fields at max, inconsistent plug map
        drain_block();
        write_reg(REG_ROTOR_LEFT, 60'd0);
        write_reg(REG_ROTOR_MIDDLE, 60'd7);
        write_reg(REG_ROTOR_RIGHT, 60'd6);
        write_reg(REG_START_POS, 60'h7FFF);
        write_reg(REG_PLUG_LOW, 60'hFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PLUG_MID, {12{5'd26}});
        write_reg(REG_PLUG_HIGH, 60'({5'd1, 5'd26}));
        send_char(8'd77);
        send_char(8'd89);
        send_char(8'd90);
        send_char(8'd65);
        send_char(8'd81);

        // position fields just past 25, and a write to an unused index
        drain_block();
        write_reg(REG_ROTOR_LEFT, 60'd5);
        write_reg(REG_ROTOR_MIDDLE, 60'd5);
        write_reg(REG_ROTOR_RIGHT, 60'd5);
        write_reg(REG_START_POS, 60'(26 | (27 << 5) | (28 << 10)));
        write_reg(REG_UNUSED, {60{1'b1}});
        send_char(8'd65);
        send_char(8'd90);
        send_char(8'd78);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_block();
            configure_random();
            set_idling(idle_mode_e'(phase % 4));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 2 && n == ITEMS_PER_PHASE / 2) drain_block();
                send_char(random_char());
            end
        end

        drain_block();
        repeat (8) @(negedge i_clk);
        if (sb.errors == 0 && sb.expected_ciphertext.size() == 0) begin
            $display("enigma_rotor_cipher_test: done, clean");
        end else begin
            $display("enigma_rotor_cipher_test: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
